>>> design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> design/dws_pkg.sv
// Shared constants and types for the deferred work scheduler
`timescale 1ns / 1ps
package dws_pkg;
    localparam int SLOTS_DEF     = 16;
    localparam int TICK_BITS_DEF = 32;
    localparam int CMD_W  = 3;
    localparam int ID_W   = 4;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 3;
    localparam int FLD_W  = 32;

    localparam logic [CMD_W-1:0] CMD_QUEUE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELAYED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STAT_W-1:0] ST_PENDING  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_RUNNING  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOCANCEL = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTRUN   = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the command
        logic decide;    // commands without a list walk, and set up list walks
        logic walk;      // one list entry per cycle
        logic finish;    // commit walk lengths, load result
    } dws_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_walk;
        logic walk_last;
    } dws_stat_t;
endpackage

>>> design/dws_datapath.sv
// Datapath: slot lists, masks, expiry memory and result register
`timescale 1ns / 1ps
module dws_datapath #(
    parameter int SLOTS     = dws_pkg::SLOTS_DEF,
    parameter int TICK_BITS = dws_pkg::TICK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dws_pkg::dws_cmd_t             cmd,
    output dws_pkg::dws_stat_t            stat,
    input  logic [dws_pkg::CMD_W-1:0]     command,
    input  logic [dws_pkg::ID_W-1:0]      work_id,
    input  logic [dws_pkg::FLD_W-1:0]     delay,
    input  logic [dws_pkg::FLD_W-1:0]     now_tick,
    output logic [dws_pkg::STAT_W-1:0]    status,
    output logic [dws_pkg::ID_W-1:0]      started_id,
    output logic [dws_pkg::CNT_W-1:0]     moved_count,
    output logic [dws_pkg::CNT_W-1:0]     ready_count,
    output logic [dws_pkg::CNT_W-1:0]     running_count
);
    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int TW = (TICK_BITS < dws_pkg::FLD_W) ? TICK_BITS : dws_pkg::FLD_W;

    logic [IW-1:0] ready_mem   [SLOTS];
    logic [IW-1:0] delayed_mem [SLOTS];
    logic [TW-1:0] expire_mem  [SLOTS];

    logic [LW-1:0]          ready_len_reg, delayed_len_reg, active_reg;
    logic [SLOTS-1:0]       pend_reg, run_reg, dly_reg;
    logic [dws_pkg::CMD_W-1:0] cmd_reg;
    logic [dws_pkg::ID_W-1:0]  id_reg;
    logic [TW-1:0]          now_reg, delay_reg;
    logic                   valid_id;
    logic [IW-1:0]          idx;

    // walk state: read pointer, write pointer, which list
    logic [LW-1:0] rd_reg, wr_reg, wlen_reg;
    logic          walk_ready_reg;   // 1: compacting ready list, 0: delayed list
    logic [dws_pkg::CNT_W-1:0] moved_reg;
    logic [dws_pkg::STAT_W-1:0] st_reg;
    logic [dws_pkg::ID_W-1:0]   start_reg;

    logic [dws_pkg::STAT_W-1:0] status_reg;
    logic [dws_pkg::ID_W-1:0]   started_reg;
    logic [dws_pkg::CNT_W-1:0]  moved_out_reg, ready_out_reg, running_out_reg;

    assign valid_id = (32'(id_reg) < SLOTS);
    assign idx = id_reg[IW-1:0];

    logic [IW-1:0] cur_entry;
    logic [TW-1:0] diff;
    logic          expired, drop;
    assign cur_entry = walk_ready_reg ? ready_mem[rd_reg[IW-1:0]]
                                      : delayed_mem[rd_reg[IW-1:0]];
    assign diff    = now_reg - expire_mem[cur_entry];
    assign expired = !diff[TW-1];
    always_comb
    begin
        if (cmd_reg == dws_pkg::CMD_TICK)
            drop = expired && (ready_len_reg < LW'(SLOTS));
        else
            drop = (cur_entry == idx);
    end

    assign stat.needs_walk = (wlen_reg != '0);
    assign stat.walk_last  = (rd_reg == wlen_reg - LW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_len_reg   <= '0;
            delayed_len_reg <= '0;
            active_reg      <= '0;
            pend_reg        <= '0;
            run_reg         <= '0;
            dly_reg         <= '0;
            wlen_reg        <= '0;
            rd_reg          <= '0;
            wr_reg          <= '0;
            walk_ready_reg  <= 1'b0;
            moved_reg       <= '0;
            st_reg          <= '0;
            start_reg       <= '0;
            status_reg      <= '0;
            started_reg     <= '0;
            moved_out_reg   <= '0;
            ready_out_reg   <= '0;
            running_out_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                cmd_reg   <= command;
                id_reg    <= work_id;
                now_reg   <= now_tick[TW-1:0];
                delay_reg <= delay[TW-1:0];
            end
            if (cmd.decide)
            begin
                st_reg    <= dws_pkg::ST_DONE;
                start_reg <= '0;
                moved_reg <= '0;
                rd_reg    <= '0;
                wr_reg    <= '0;
                wlen_reg  <= '0;
                case (cmd_reg)
                    dws_pkg::CMD_QUEUE:
                        if (!valid_id || pend_reg[idx])
                            st_reg <= dws_pkg::ST_PENDING;
                        else if (ready_len_reg < LW'(SLOTS))
                        begin
                            pend_reg[idx] <= 1'b1;
                            ready_mem[ready_len_reg[IW-1:0]] <= idx;
                            ready_len_reg <= ready_len_reg + LW'(1);
                        end
                    dws_pkg::CMD_DELAYED:
                        if (!valid_id || pend_reg[idx])
                            st_reg <= dws_pkg::ST_PENDING;
                        else if (delayed_len_reg < LW'(SLOTS))
                        begin
                            pend_reg[idx] <= 1'b1;
                            dly_reg[idx]  <= 1'b1;
                            expire_mem[idx] <= now_reg + delay_reg;
                            delayed_mem[delayed_len_reg[IW-1:0]] <= idx;
                            delayed_len_reg <= delayed_len_reg + LW'(1);
                        end
                    dws_pkg::CMD_TICK:
                    begin
                        walk_ready_reg <= 1'b0;
                        wlen_reg       <= delayed_len_reg;
                    end
                    dws_pkg::CMD_RUN:
                        if (ready_len_reg == '0)
                            st_reg <= dws_pkg::ST_EMPTY;
                        else
                        begin
                            // head is unique in the list; compact it out by walking
                            id_reg         <= dws_pkg::ID_W'(ready_mem[0]);
                            start_reg      <= dws_pkg::ID_W'(ready_mem[0]);
                            pend_reg[ready_mem[0]] <= 1'b0;
                            if (!run_reg[ready_mem[0]])
                            begin
                                run_reg[ready_mem[0]] <= 1'b1;
                                active_reg <= active_reg + LW'(1);
                            end
                            walk_ready_reg <= 1'b1;
                            wlen_reg       <= ready_len_reg;
                        end
                    dws_pkg::CMD_FINISH:
                        if (valid_id && run_reg[idx])
                        begin
                            run_reg[idx] <= 1'b0;
                            if (active_reg != '0)
                                active_reg <= active_reg - LW'(1);
                        end
                        else
                            st_reg <= dws_pkg::ST_NOTRUN;
                    dws_pkg::CMD_CANCEL:
                        if (valid_id && pend_reg[idx])
                        begin
                            pend_reg[idx] <= 1'b0;
                            dly_reg[idx]  <= 1'b0;
                            walk_ready_reg <= !dly_reg[idx];
                            wlen_reg <= dly_reg[idx] ? delayed_len_reg : ready_len_reg;
                        end
                        else if (valid_id && run_reg[idx])
                            st_reg <= dws_pkg::ST_RUNNING;
                        else
                            st_reg <= dws_pkg::ST_NOCANCEL;
                    default: ;
                endcase
            end
            if (cmd.walk)
            begin
                rd_reg <= rd_reg + LW'(1);
                if (drop)
                begin
                    if (cmd_reg == dws_pkg::CMD_TICK)
                    begin
                        dly_reg[cur_entry] <= 1'b0;
                        ready_mem[ready_len_reg[IW-1:0]] <= cur_entry;
                        ready_len_reg <= ready_len_reg + LW'(1);
                        moved_reg <= moved_reg + dws_pkg::CNT_W'(1);
                    end
                end
                else
                begin
                    if (walk_ready_reg)
                        ready_mem[wr_reg[IW-1:0]] <= cur_entry;
                    else
                        delayed_mem[wr_reg[IW-1:0]] <= cur_entry;
                    wr_reg <= wr_reg + LW'(1);
                end
            end
            if (cmd.finish)
            begin
                if (wlen_reg != '0)
                begin
                    if (walk_ready_reg)
                        ready_len_reg <= wr_reg;
                    else
                        delayed_len_reg <= wr_reg;
                end
                status_reg      <= st_reg;
                started_reg     <= start_reg;
                moved_out_reg   <= moved_reg;
                ready_out_reg   <= dws_pkg::CNT_W'((wlen_reg != '0 && walk_ready_reg)
                                   ? wr_reg : ready_len_reg);
                running_out_reg <= dws_pkg::CNT_W'(active_reg);
            end
        end
    end

    assign status        = status_reg;
    assign started_id    = started_reg;
    assign moved_count   = moved_out_reg;
    assign ready_count   = ready_out_reg;
    assign running_count = running_out_reg;
endmodule

>>> design/dws_ctrl.sv
// Controller: command sequencing and output handshake
`timescale 1ns / 1ps
module dws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output dws_pkg::dws_cmd_t  cmd,
    input  dws_pkg::dws_stat_t stat
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_DONE   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // a finished result may sit in the output while the next command is taken
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
                if (!stat.needs_walk)
                    state_next = S_DONE;
                else
                begin
                    cmd.walk = 1'b1;
                    if (stat.walk_last)
                        state_next = S_DONE;
                end
            S_DONE:
                if (!ov_next)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

>>> design/deferred_work_scheduler_top.sv
// Deferred work scheduler top level
// Commands step through load, decide, walk and done; tick, run and cancel walk a list.
// A new command is taken only after the last result is loaded into the output register.
// The next command is taken while a result still waits in the output register.
// Reset (rst_n low, asynchronous) empties both lists and clears all slot masks.
`timescale 1ns / 1ps
module deferred_work_scheduler_top #(
    parameter int SLOTS     = dws_pkg::SLOTS_DEF,
    parameter int TICK_BITS = dws_pkg::TICK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dws_pkg::CMD_W-1:0]     command,
    input  logic [dws_pkg::ID_W-1:0]      work_id,
    input  logic [dws_pkg::FLD_W-1:0]     delay,
    input  logic [dws_pkg::FLD_W-1:0]     now_tick,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dws_pkg::STAT_W-1:0]    status,
    output logic [dws_pkg::ID_W-1:0]      started_id,
    output logic [dws_pkg::CNT_W-1:0]     moved_count,
    output logic [dws_pkg::CNT_W-1:0]     ready_count,
    output logic [dws_pkg::CNT_W-1:0]     running_count
);
    dws_pkg::dws_cmd_t  cmd;
    dws_pkg::dws_stat_t stat;

    dws_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    dws_datapath #(.SLOTS(SLOTS), .TICK_BITS(TICK_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .command(command), .work_id(work_id), .delay(delay),
        .now_tick(now_tick), .status(status), .started_id(started_id),
        .moved_count(moved_count), .ready_count(ready_count),
        .running_count(running_count)
    );
endmodule

>>> design/dws_checker.sv
// Port-level checker for the deferred work scheduler, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dws_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [dws_pkg::STAT_W-1:0] status,
    input logic [dws_pkg::ID_W-1:0]   started_id,
    input logic [dws_pkg::CNT_W-1:0]  moved_count,
    input logic [dws_pkg::CNT_W-1:0]  ready_count,
    input logic [dws_pkg::CNT_W-1:0]  running_count
);
    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall,
        "input not stalled after a transfer")
    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status), "stalled result changed")
    `ASSERT_IMPL(a_started_zero, clk, rst_n, out_valid && status != dws_pkg::ST_DONE,
        started_id == '0, "started id set on a refused command")
    `ASSERT_IMPL(a_moved_bound, clk, rst_n, out_valid, moved_count <= ready_count,
        "more moved than ready")
    `ASSERT_IMPL(a_running_bound, clk, rst_n, out_valid,
        running_count <= dws_pkg::CNT_W'(dws_pkg::SLOTS_DEF), "running count above slots")
endmodule

bind deferred_work_scheduler_top dws_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .started_id(started_id), .moved_count(moved_count),
    .ready_count(ready_count), .running_count(running_count)
);

>>> test/tb.sv
// Self-checking testbench for the deferred work scheduler top level
`timescale 1ns / 1ps
module tb;
    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [dws_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [dws_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [dws_pkg::CMD_W-1:0] cmd;
        logic [dws_pkg::ID_W-1:0]  id;
        logic [31:0]               dly;
        logic [31:0]               now;
    } job_t;

    typedef struct packed {
        logic [dws_pkg::STAT_W-1:0] status;
        logic [dws_pkg::ID_W-1:0]   started;
        logic [dws_pkg::CNT_W-1:0]  moved;
        logic [dws_pkg::CNT_W-1:0]  ready;
        logic [dws_pkg::CNT_W-1:0]  running;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [dws_pkg::CMD_W-1:0] command = '0;
    logic [dws_pkg::ID_W-1:0] work_id = '0;
    logic [dws_pkg::FLD_W-1:0] delay = '0;
    logic [dws_pkg::FLD_W-1:0] now_tick = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [dws_pkg::STAT_W-1:0] status;
    logic [dws_pkg::ID_W-1:0] started_id;
    logic [dws_pkg::CNT_W-1:0] moved_count;
    logic [dws_pkg::CNT_W-1:0] ready_count;
    logic [dws_pkg::CNT_W-1:0] running_count;

    deferred_work_scheduler_top DUT (.*);

    job_t     cmd_backlog[$];
    outcome_t outcome_fifo[$];
    int       errors = 0;
    int       sent = 0;
    int       seen = 0;
    int       cycle = 0;
    int       quiet_cycles = 0;
    int       moved_total = 0;

    // scheduler shadow state
    logic [dws_pkg::ID_W-1:0] ready_q[$];
    logic [dws_pkg::ID_W-1:0] delayed_q[$];
    logic [31:0]     expiry[NSLOT];
    logic [NSLOT-1:0] pend_m = '0;
    logic [NSLOT-1:0] run_m = '0;
    logic [NSLOT-1:0] dly_m = '0;
    int               active = 0;

    initial forever #5 clk = ~clk;

    task automatic schedule_cmd(input job_t j);
        outcome_t o;
        logic [NSLOT-1:0] b;
        logic [dws_pkg::ID_W-1:0] s;
        logic [31:0] diff;
        logic [dws_pkg::ID_W-1:0] keep[$];
        int idx;
        o = '0;
        b = NSLOT'(1) << j.id;
        idx = -1;
        case (j.cmd)
            dws_pkg::CMD_QUEUE:
                if (pend_m & b) o.status = dws_pkg::ST_PENDING;
                else if (ready_q.size() < NSLOT)
                begin
                    pend_m |= b;
                    ready_q.push_back(j.id);
                end
            dws_pkg::CMD_DELAYED:
                if (pend_m & b) o.status = dws_pkg::ST_PENDING;
                else if (delayed_q.size() < NSLOT)
                begin
                    pend_m |= b;
                    dly_m |= b;
                    expiry[j.id] = j.now + j.dly;
                    delayed_q.push_back(j.id);
                end
            dws_pkg::CMD_TICK:
            begin
                foreach (delayed_q[k])
                begin
                    s = delayed_q[k];
                    diff = j.now - expiry[s];
                    if (!diff[31] && ready_q.size() < NSLOT)
                    begin
                        dly_m[s] = 1'b0;
                        ready_q.push_back(s);
                        o.moved++;
                    end
                    else keep.push_back(s);
                end
                delayed_q = keep;
                moved_total += o.moved;
            end
            dws_pkg::CMD_RUN:
                if (ready_q.size() == 0) o.status = dws_pkg::ST_EMPTY;
                else
                begin
                    s = ready_q.pop_front();
                    pend_m[s] = 1'b0;
                    if (!run_m[s])
                    begin
                        run_m[s] = 1'b1;
                        active++;
                    end
                    o.started = s;
                end
            dws_pkg::CMD_FINISH:
                if (run_m & b)
                begin
                    run_m &= ~b;
                    if (active > 0) active--;
                end
                else o.status = dws_pkg::ST_NOTRUN;
            dws_pkg::CMD_CANCEL:
                if (pend_m & b)
                begin
                    // slot ids are unique on each list
                    if (dly_m & b)
                    begin
                        foreach (delayed_q[k]) if (delayed_q[k] == j.id) idx = k;
                        delayed_q.delete(idx);
                        dly_m &= ~b;
                    end
                    else
                    begin
                        foreach (ready_q[k]) if (ready_q[k] == j.id) idx = k;
                        ready_q.delete(idx);
                    end
                    pend_m &= ~b;
                end
                else if (run_m & b) o.status = dws_pkg::ST_RUNNING;
                else o.status = dws_pkg::ST_NOCANCEL;
            default: ;
        endcase
        o.ready = dws_pkg::CNT_W'(ready_q.size());
        o.running = dws_pkg::CNT_W'(active);
        outcome_fifo.push_back(o);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("result %0d: %s got %0d, want %0d", seen, what, got, want);
    endtask

    function automatic bit idle_now(input int n);
        // calm window in the middle of the run
        if (n > 4000 && n < 7000) return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        job_t j;
        if (!rst_n) in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                schedule_cmd({command, work_id, delay, now_tick});
                sent++;
            end
            if (cmd_backlog.size() > 0 && !idle_now(cycle))
            begin
                j = cmd_backlog.pop_front();
                command <= j.cmd;
                work_id <= j.id;
                delay <= j.dly;
                now_tick <= j.now;
                in_valid <= 1'b1;
            end
            else in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t w;
        if (!rst_n) out_stall <= 1'b0;
        else
        begin
            cycle <= cycle + 1;
            if (out_valid && !out_stall)
            begin
                if (outcome_fifo.size() == 0)
                begin
                    errors++;
                    $display("result %0d: transfer with nothing expected", seen);
                end
                else
                begin
                    w = outcome_fifo.pop_front();
                    if (status !== w.status) report("status", status, w.status);
                    if (started_id !== w.started) report("started_id", started_id, w.started);
                    if (moved_count !== w.moved) report("moved_count", moved_count, w.moved);
                    if (ready_count !== w.ready) report("ready_count", ready_count, w.ready);
                    if (running_count !== w.running)
                        report("running_count", running_count, w.running);
                end
                seen <= seen + 1;
            end
            out_stall <= idle_now(cycle);
        end
    end

    // watchdog on transfers of either side
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)
                      || (cmd_backlog.size() == 0 && outcome_fifo.size() == 0)))
            quiet_cycles <= 0;
        else if (rst_n) quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("deferred_work_scheduler_top: mismatch");
            $finish;
        end
    end

    function automatic job_t mk(input logic [dws_pkg::CMD_W-1:0] c, input int id,
                                input logic [31:0] d, input logic [31:0] t);
        job_t j;
        j.cmd = c;
        j.id = dws_pkg::ID_W'(id);
        j.dly = d;
        j.now = t;
        return j;
    endfunction

    initial
    begin
        logic [31:0] tnow;
        int r;
        job_t j;
        // directed: refusals, both lists, expiry edges, cancel paths, spare codes
        cmd_backlog.push_back(mk(dws_pkg::CMD_RUN, 0, 0, 0));
        cmd_backlog.push_back(mk(dws_pkg::CMD_QUEUE, 0, 0, 0));
        cmd_backlog.push_back(mk(dws_pkg::CMD_QUEUE, 0, 0, 0));
        cmd_backlog.push_back(mk(dws_pkg::CMD_QUEUE, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        cmd_backlog.push_back(mk(dws_pkg::CMD_DELAYED, 3, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_DELAYED, 4, 32'hFFFF_FFFF, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_DELAYED, 5, 32'h8000_0000, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_DELAYED, 6, 32'h7FFF_FFFF, 32'hFFFF_FFF0));
        cmd_backlog.push_back(mk(dws_pkg::CMD_DELAYED, 6, 1, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_TICK, 0, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_RUN, 0, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_RUN, 0, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_QUEUE, 0, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_RUN, 0, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_CANCEL, 0, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_CANCEL, 3, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_CANCEL, 5, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_CANCEL, 9, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_FINISH, 9, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_FINISH, 0, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_FINISH, 15, 0, 100));
        cmd_backlog.push_back(mk(CMD_SPARE6, 7, 0, 100));
        cmd_backlog.push_back(mk(CMD_SPARE7, 7, 0, 100));
        cmd_backlog.push_back(mk(dws_pkg::CMD_TICK, 0, 0, 32'h7FFF_FFFF));
        tnow = $urandom_range(0, 1) ? 32'hFFFF_FF00 : $urandom;
        for (int n = 0; n < 1026; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3) tnow = $urandom;
            else tnow += $urandom_range(0, 6);
            j.now = tnow;
            j.id = dws_pkg::ID_W'($urandom_range(0, NSLOT - 1));
            r = $urandom_range(0, 99);
            j.dly = r < 80 ? $urandom_range(0, 24)
                  : r < 90 ? $urandom : 32'h7FFF_FFF0 + $urandom_range(0, 31);
            r = $urandom_range(0, 99);
            j.cmd = r < 22 ? dws_pkg::CMD_QUEUE : r < 42 ? dws_pkg::CMD_DELAYED
                  : r < 58 ? dws_pkg::CMD_TICK : r < 76 ? dws_pkg::CMD_RUN
                  : r < 90 ? dws_pkg::CMD_FINISH : r < 98 ? dws_pkg::CMD_CANCEL
                  : r < 99 ? CMD_SPARE6 : CMD_SPARE7;
            cmd_backlog.push_back(j);
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (cmd_backlog.size() != 0 || in_valid || outcome_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d commands sent, %0d results checked, %0d slots moved by ticks",
                 sent, seen, moved_total);
        if (errors == 0)
            $display("deferred_work_scheduler_top: match");
        else
            $display("deferred_work_scheduler_top: mismatch");
        $finish;
    end
endmodule
